@@ hdl/iol_pkg.sv @@
// Package for the indexed ordered list unit.
// Holds sizes, command and status codes, cell ops and control structs.
// Used by the interfaces, the decoder, the cells and the top level.
package iol_pkg;

    localparam int CAPACITY   = 16;
    localparam int DATA_WIDTH = 32;
    localparam int CMD_W      = 4;
    localparam int POS_W      = 8;
    localparam int STAT_W     = 2;
    localparam int CNT_W      = $clog2(CAPACITY + 1);
    localparam int IDX_W      = $clog2(CAPACITY);

    typedef enum logic [CMD_W-1:0] {
        CMD_APPEND  = 4'd0,
        CMD_PREPEND = 4'd1,
        CMD_INSERT  = 4'd2,
        CMD_POP_FRT = 4'd3,
        CMD_POP_BCK = 4'd4,
        CMD_ERASE   = 4'd5,
        CMD_GET     = 4'd6,
        CMD_FRONT   = 4'd7,
        CMD_BACK    = 4'd8,
        CMD_CLEAR   = 4'd9
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_INDEX = 2'd1,
        ST_EMPTY = 2'd2,
        ST_FULL  = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_DELETE = 2'd2
    } t_cell_op;

    // Broadcast to every cell in a cycle
    typedef struct packed {
        t_cell_op              op;
        logic [IDX_W-1:0]      k;
        logic [DATA_WIDTH-1:0] data;
    } t_cell_ctl;

    // Decoded request, from the decoder to the top level
    typedef struct packed {
        t_status          status;
        t_cell_op         op;
        logic [IDX_W-1:0] k;
        logic             rd_en;
        logic [IDX_W-1:0] rd_idx;
        logic [CNT_W-1:0] n_fill;
    } t_dec;

endpackage

@@ hdl/iol_if.sv @@
// Request and response channel interfaces of the indexed ordered list unit.
// Depends on iol_pkg for field widths.
interface iol_req_if;
    logic                           valid;
    logic                           ready;
    logic [iol_pkg::CMD_W-1:0]      cmd;
    logic [iol_pkg::POS_W-1:0]      position;
    logic [iol_pkg::DATA_WIDTH-1:0] value;

    modport source (output valid, output cmd, output position, output value, input ready);
    modport sink   (input valid, input cmd, input position, input value, output ready);
endinterface

interface iol_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [iol_pkg::STAT_W-1:0]     status;
    logic [iol_pkg::DATA_WIDTH-1:0] read_data;
    logic [iol_pkg::CNT_W-1:0]      count;
    logic                           is_empty;

    modport source (output valid, output status, output read_data, output count,
                    output is_empty, input ready);
    modport sink   (input valid, input status, input read_data, input count,
                    input is_empty, output ready);
endinterface

@@ hdl/iol_ctrl.sv @@
// Request decoder: picks status, cell op, gap position, read slot and new count.
// Depends on iol_pkg.
module iol_ctrl (
    input  logic [iol_pkg::CMD_W-1:0] i_cmd,
    input  logic [iol_pkg::POS_W-1:0] i_position,
    input  logic [iol_pkg::CNT_W-1:0] i_fill,
    output iol_pkg::t_dec             o_dec
);
    import iol_pkg::*;

    localparam int CMP_W = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;

    logic [CMP_W-1:0] w_pos;
    logic [CMP_W-1:0] w_fill;
    logic [CMP_W-1:0] w_at;
    logic             w_empty;
    logic             w_full;
    logic [IDX_W-1:0] w_last;

    assign w_pos   = CMP_W'(i_position);
    assign w_fill  = CMP_W'(i_fill);
    assign w_empty = (i_fill == '0);
    assign w_full  = (i_fill >= CNT_W'(CAPACITY));
    assign w_last  = IDX_W'(i_fill - CNT_W'(1));

    // Pick the insert slot
    always_comb begin
        case (t_cmd'(i_cmd))
            CMD_APPEND:  w_at = w_fill;
            CMD_PREPEND: w_at = '0;
            default:     w_at = w_pos;
        endcase
    end

    // Decode the request against the current count
    always_comb begin
        o_dec.status = ST_OK;
        o_dec.op     = CELL_HOLD;
        o_dec.k      = '0;
        o_dec.rd_en  = 1'b0;
        o_dec.rd_idx = '0;
        o_dec.n_fill = i_fill;
        case (t_cmd'(i_cmd))
            CMD_APPEND, CMD_PREPEND, CMD_INSERT: begin
                if (w_at > w_fill) begin
                    o_dec.status = ST_INDEX;
                end else if (w_full) begin
                    o_dec.status = ST_FULL;
                end else begin
                    o_dec.op     = CELL_INSERT;
                    o_dec.k      = IDX_W'(w_at);
                    o_dec.n_fill = i_fill + CNT_W'(1);
                end
            end
            CMD_POP_FRT, CMD_POP_BCK: begin
                if (w_empty) begin
                    o_dec.status = ST_EMPTY;
                end else begin
                    o_dec.op     = CELL_DELETE;
                    o_dec.k      = (t_cmd'(i_cmd) == CMD_POP_FRT) ? '0 : w_last;
                    o_dec.rd_en  = 1'b1;
                    o_dec.rd_idx = o_dec.k;
                    o_dec.n_fill = i_fill - CNT_W'(1);
                end
            end
            CMD_ERASE: begin
                if (w_empty) begin
                    o_dec.status = ST_EMPTY;
                end else if (w_pos >= w_fill) begin
                    o_dec.status = ST_INDEX;
                end else begin
                    o_dec.op     = CELL_DELETE;
                    o_dec.k      = IDX_W'(w_pos);
                    o_dec.rd_en  = 1'b1;
                    o_dec.rd_idx = IDX_W'(w_pos);
                    o_dec.n_fill = i_fill - CNT_W'(1);
                end
            end
            CMD_GET: begin
                if (w_pos >= w_fill) begin
                    o_dec.status = ST_INDEX;
                end else begin
                    o_dec.rd_en  = 1'b1;
                    o_dec.rd_idx = IDX_W'(w_pos);
                end
            end
            CMD_FRONT, CMD_BACK: begin
                if (w_empty) begin
                    o_dec.status = ST_EMPTY;
                end else begin
                    o_dec.rd_en  = 1'b1;
                    o_dec.rd_idx = (t_cmd'(i_cmd) == CMD_FRONT) ? '0 : w_last;
                end
            end
            CMD_CLEAR: begin
                o_dec.n_fill = '0;
            end
            default: begin
            end
        endcase
    end

endmodule

@@ hdl/iol_cell.sv @@
// One list slot: holds a word and shifts it toward a neighbor on insert or erase.
// Depends on iol_pkg.
module iol_cell (
    input  logic                           i_clk,
    input  iol_pkg::t_cell_ctl             i_ctl,
    input  logic [iol_pkg::IDX_W-1:0]      i_index,
    input  logic [iol_pkg::DATA_WIDTH-1:0] i_left,
    input  logic [iol_pkg::DATA_WIDTH-1:0] i_right,
    output logic [iol_pkg::DATA_WIDTH-1:0] o_word
);
    import iol_pkg::*;

    logic [DATA_WIDTH-1:0] r_word;
    logic [DATA_WIDTH-1:0] n_word;

    // Take the left neighbor above the gap, the new word at it, the right one on erase
    always_comb begin
        n_word = r_word;
        case (i_ctl.op)
            CELL_INSERT: begin
                if (i_index > i_ctl.k) begin
                    n_word = i_left;
                end else if (i_index == i_ctl.k) begin
                    n_word = i_ctl.data;
                end
            end
            CELL_DELETE: begin
                if (i_index >= i_ctl.k) begin
                    n_word = i_right;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_word = r_word;

endmodule

@@ hdl/indexed_ordered_list_unit.sv @@
// Channel  | Dir | Fields                                  | Accepted when
// i_req    | in  | cmd[4] position[8] value[32]            | valid && ready
// o_rsp    | out | status[2] read_data[32] count[5] is_empty | valid && ready
//
// Top level of the indexed ordered list unit; uses iol_pkg, iol_if, iol_ctrl, iol_cell.
// One request per cycle while the sink keeps up; its response appears in the output
// register the cycle after. All cells shift in parallel on insert and erase.
// Reset clears the count and the response valid; cell contents are not cleared.
// A response held by a stalled sink blocks new requests until it is taken.
module indexed_ordered_list_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    iol_req_if.sink      i_req,
    iol_rsp_if.source    o_rsp
);
    import iol_pkg::*;

    logic                  w_acc;
    t_dec                  w_dec;
    t_cell_ctl             w_ctl;
    logic [DATA_WIDTH-1:0] w_word [CAPACITY];
    logic [DATA_WIDTH-1:0] w_rd;

    logic [CNT_W-1:0]      r_fill;
    logic                  r_out_valid;
    t_status               r_status;
    logic [DATA_WIDTH-1:0] r_read_data;
    logic [CNT_W-1:0]      r_count;
    logic                  r_is_empty;

    // Accept a request whenever the output register is free or being drained
    assign i_req.ready = !r_out_valid || o_rsp.ready;
    assign w_acc       = i_req.valid && i_req.ready;

    iol_ctrl u_ctrl (
        .i_cmd      (i_req.cmd),
        .i_position (i_req.position),
        .i_fill     (r_fill),
        .o_dec      (w_dec)
    );

    // Broadcast the cell op only for an accepted request
    assign w_ctl.op   = w_acc ? w_dec.op : CELL_HOLD;
    assign w_ctl.k    = w_dec.k;
    assign w_ctl.data = i_req.value;

    // Chain of cells, front at slot zero
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [DATA_WIDTH-1:0] w_left;
        logic [DATA_WIDTH-1:0] w_right;
        if (g == 0) begin : g_first
            assign w_left = '0;
        end else begin : g_mid_l
            assign w_left = w_word[g-1];
        end
        if (g == CAPACITY - 1) begin : g_last
            assign w_right = '0;
        end else begin : g_mid_r
            assign w_right = w_word[g+1];
        end
        iol_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_index (IDX_W'(g)),
            .i_left  (w_left),
            .i_right (w_right),
            .o_word  (w_word[g])
        );
    end

    // Select the word being read or removed
    assign w_rd = w_dec.rd_en ? w_word[w_dec.rd_idx] : '0;

    // Advance the count and the response valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_acc) begin
                r_fill      <= w_dec.n_fill;
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Load the response payload
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_status    <= w_dec.status;
            r_read_data <= w_rd;
            r_count     <= w_dec.n_fill;
            r_is_empty  <= (w_dec.n_fill == '0);
        end
    end

    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.status    = r_status;
    assign o_rsp.read_data = r_read_data;
    assign o_rsp.count     = r_count;
    assign o_rsp.is_empty  = r_is_empty;

`ifndef ASSERT_OFF
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CNT_W'(CAPACITY))
        else $error("count above capacity");

    a_acc_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc |=> r_out_valid)
        else $error("accepted request left no response");

    a_fill_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_acc |=> $stable(r_fill))
        else $error("count changed without a request");

    a_rsp_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_count == r_fill) && (r_is_empty == (r_count == '0)))
        else $error("response count disagrees with stored count");

    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_status == ST_FULL) |-> (r_count == CNT_W'(CAPACITY)))
        else $error("full status with room left");
`endif

endmodule

@@ tb/sv/indexed_ordered_list_unit_tb.sv @@
// Self-checking testbench of the indexed ordered list unit: a scoreboard keeps its own
// copy of the list, predicts each response and compares it field by field.
// Depends on iol_pkg, iol_if and the indexed_ordered_list_unit top level.

// One expected response
typedef struct packed {
    iol_pkg::t_status                status;
    logic [iol_pkg::DATA_WIDTH-1:0]  read_data;
    logic [iol_pkg::CNT_W-1:0]       count;
    logic                            is_empty;
} t_list_result;

class list_scoreboard;
    logic [iol_pkg::DATA_WIDTH-1:0] cells [iol_pkg::CAPACITY];
    int unsigned                    fill;
    t_list_result                   expected_q [$];
    int unsigned                    errors;
    int unsigned                    rsp_seen;

    function new();
        foreach (cells[i]) cells[i] = '0;
        fill     = 0;
        errors   = 0;
        rsp_seen = 0;
    endfunction

    function int pending();
        return expected_q.size();
    endfunction

    // Apply one accepted request to the list copy and queue its response
    function void note_request(input logic [iol_pkg::CMD_W-1:0] cmd,
                               input logic [iol_pkg::POS_W-1:0] pos,
                               input logic [iol_pkg::DATA_WIDTH-1:0] val);
        int unsigned      at;
        int unsigned      i;
        iol_pkg::t_status st;
        logic [iol_pkg::DATA_WIDTH-1:0] rd;
        t_list_result     res;
        st = iol_pkg::ST_OK;
        rd = '0;
        case (cmd)
            iol_pkg::CMD_APPEND, iol_pkg::CMD_PREPEND, iol_pkg::CMD_INSERT: begin
                if (cmd == iol_pkg::CMD_APPEND) at = fill;
                else if (cmd == iol_pkg::CMD_PREPEND) at = 0;
                else at = pos;
                // index error wins over full
                if (at > fill) begin
                    st = iol_pkg::ST_INDEX;
                end else if (fill >= iol_pkg::CAPACITY) begin
                    st = iol_pkg::ST_FULL;
                end else begin
                    for (i = fill; i > at; i--) cells[i] = cells[i-1];
                    cells[at] = val;
                    fill++;
                end
            end
            iol_pkg::CMD_POP_FRT, iol_pkg::CMD_POP_BCK: begin
                if (fill == 0) begin
                    st = iol_pkg::ST_EMPTY;
                end else begin
                    at = (cmd == iol_pkg::CMD_POP_FRT) ? 0 : fill - 1;
                    rd = cells[at];
                    for (i = at; i + 1 < fill; i++) cells[i] = cells[i+1];
                    fill--;
                end
            end
            iol_pkg::CMD_ERASE: begin
                if (fill == 0) begin
                    st = iol_pkg::ST_EMPTY;
                end else if (pos >= fill) begin
                    st = iol_pkg::ST_INDEX;
                end else begin
                    rd = cells[pos];
                    for (i = pos; i + 1 < fill; i++) cells[i] = cells[i+1];
                    fill--;
                end
            end
            iol_pkg::CMD_GET: begin
                if (pos >= fill) st = iol_pkg::ST_INDEX;
                else rd = cells[pos];
            end
            iol_pkg::CMD_FRONT, iol_pkg::CMD_BACK: begin
                if (fill == 0) st = iol_pkg::ST_EMPTY;
                else rd = cells[(cmd == iol_pkg::CMD_FRONT) ? 0 : fill - 1];
            end
            iol_pkg::CMD_CLEAR: begin
                fill = 0;
            end
            default: begin
            end
        endcase
        res.status    = st;
        res.read_data = rd;
        res.count     = fill[iol_pkg::CNT_W-1:0];
        res.is_empty  = (fill == 0);
        expected_q.push_back(res);
    endfunction

    task report(input string msg);
        $display("MISMATCH: %s", msg);
        errors++;
    endtask

    // Compare one accepted response with the oldest expectation
    task check_response(input logic [iol_pkg::STAT_W-1:0] status,
                        input logic [iol_pkg::DATA_WIDTH-1:0] read_data,
                        input logic [iol_pkg::CNT_W-1:0] count,
                        input logic is_empty);
        t_list_result want;
        if (expected_q.size() == 0) begin
            report($sformatf("response with no request waiting: status %0d count %0d",
                             status, count));
        end else begin
            want = expected_q[0];
            expected_q.delete(0);
            if (status !== want.status)
                report($sformatf("response %0d status: expected %0d got %0d",
                                 rsp_seen, want.status, status));
            if (read_data !== want.read_data)
                report($sformatf("response %0d read_data: expected %h got %h",
                                 rsp_seen, want.read_data, read_data));
            if (count !== want.count)
                report($sformatf("response %0d count: expected %0d got %0d",
                                 rsp_seen, want.count, count));
            if (is_empty !== want.is_empty)
                report($sformatf("response %0d is_empty: expected %0b got %0b",
                                 rsp_seen, want.is_empty, is_empty));
        end
        rsp_seen++;
    endtask
endclass

module indexed_ordered_list_unit_tb;
    import iol_pkg::*;

    localparam int RANDOM_ITEMS = 650;
    localparam int QUIET_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 8;
    localparam logic [CMD_W-1:0] CMD_LAST_CODE = '1;

    logic i_clk = 1'b0;
    logic i_rst_n;

    iol_req_if req_if ();
    iol_rsp_if rsp_if ();

    indexed_ordered_list_unit i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    list_scoreboard sb;
    int unsigned    send_idle_pct = 0;
    int unsigned    rcv_stall_pct = 0;
    int unsigned    quiet_cycles  = 0;
    int unsigned    level         = 0;   // driver's view of the count, used to aim positions

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Stall the response side at random
    always @(posedge i_clk) begin
        if (rcv_stall_pct != 0 && $urandom_range(99) < rcv_stall_pct) rsp_if.ready <= 1'b0;
        else rsp_if.ready <= 1'b1;
    end

    // Sample both handshakes, check, and watch for a hang
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (req_if.valid && req_if.ready)
                sb.note_request(req_if.cmd, req_if.position, req_if.value);
            if (rsp_if.valid && rsp_if.ready)
                sb.check_response(rsp_if.status, rsp_if.read_data, rsp_if.count,
                                  rsp_if.is_empty);
            if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("indexed_ordered_list_unit_tb failed");
                $finish;
            end
        end
    end

    // Track the count the driver expects, to steer positions toward valid ones
    function automatic void advance_level(input logic [CMD_W-1:0] cmd,
                                          input logic [POS_W-1:0] pos);
        case (cmd)
            CMD_APPEND, CMD_PREPEND: if (level < CAPACITY) level++;
            CMD_INSERT: if (pos <= level && level < CAPACITY) level++;
            CMD_POP_FRT, CMD_POP_BCK: if (level > 0) level--;
            CMD_ERASE: if (pos < level) level--;
            CMD_CLEAR: level = 0;
            default: begin
            end
        endcase
    endfunction

    // Offer one request, idling first at random, and hold it until taken
    task automatic send_request(input logic [CMD_W-1:0] cmd,
                                input logic [POS_W-1:0] pos,
                                input logic [DATA_WIDTH-1:0] val);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid    <= 1'b1;
        req_if.cmd      <= cmd;
        req_if.position <= pos;
        req_if.value    <= val;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        advance_level(cmd, pos);
    endtask

    task automatic run_directed();
        // empty-list corners
        send_request(CMD_GET, 8'd0, '0);
        send_request(CMD_ERASE, 8'hFF, '0);
        send_request(CMD_POP_FRT, 8'd0, '0);
        send_request(CMD_POP_BCK, 8'd0, '0);
        send_request(CMD_FRONT, 8'd0, '0);
        send_request(CMD_BACK, 8'd0, '0);
        send_request(CMD_INSERT, 8'd1, 32'h1111_1111);
        // build a short list through every way of adding
        send_request(CMD_INSERT, 8'd0, 32'h0000_0000);
        send_request(CMD_APPEND, 8'hFF, 32'hFFFF_FFFF);
        send_request(CMD_PREPEND, 8'hAA, 32'hA5A5_A5A5);
        send_request(CMD_INSERT, 8'd3, 32'h5A5A_5A5A);
        send_request(CMD_INSERT, 8'd2, 32'h8000_0001);
        // reads in and out of range
        send_request(CMD_GET, 8'd4, '0);
        send_request(CMD_GET, 8'd5, '0);
        send_request(CMD_GET, 8'hFF, '0);
        send_request(CMD_FRONT, 8'd0, '0);
        send_request(CMD_BACK, 8'd0, '0);
        // removals
        send_request(CMD_ERASE, 8'd2, '0);
        send_request(CMD_ERASE, 8'd4, '0);
        send_request(CMD_POP_FRT, 8'd0, '0);
        send_request(CMD_POP_BCK, 8'd0, '0);
        // unknown codes, then clear
        send_request(CMD_LAST_CODE, 8'h55, 32'hDEAD_BEEF);
        send_request(CMD_W'(CMD_CLEAR + 1), 8'h00, 32'h1234_5678);
        send_request(CMD_CLEAR, 8'd0, '0);
        send_request(CMD_FRONT, 8'd0, '0);
    endtask

    // Random requests in runs that grow, shrink or churn the list
    task automatic run_random(input int unsigned n);
        int unsigned      k;
        int unsigned      mode;
        int unsigned      run_left;
        int unsigned      r;
        int unsigned      add_pct;
        logic [CMD_W-1:0] cmd;
        logic [POS_W-1:0] pos;
        logic [DATA_WIDTH-1:0] val;
        run_left = 0;
        mode     = 0;
        for (k = 0; k < n; k++) begin
            if (run_left == 0) begin
                mode     = $urandom_range(2);
                run_left = $urandom_range(8, 40);
            end
            run_left--;
            add_pct = (mode == 0) ? 67 : ((mode == 1) ? 27 : 50);
            r = $urandom_range(99);
            if (r < 4) cmd = CMD_W'($urandom_range(CMD_CLEAR + 1, CMD_LAST_CODE));
            else if (r < 7) cmd = CMD_CLEAR;
            else if (r < 7 + add_pct) cmd = CMD_W'($urandom_range(CMD_APPEND, CMD_INSERT));
            else cmd = CMD_W'($urandom_range(CMD_POP_FRT, CMD_BACK));
            // mostly valid positions, some just past the end, some anywhere
            r = $urandom_range(99);
            if (r < 10) pos = POS_W'($urandom);
            else if (r < 25) pos = POS_W'(level + $urandom_range(0, 2));
            else if (cmd == CMD_INSERT) pos = POS_W'($urandom_range(0, level));
            else pos = (level == 0) ? '0 : POS_W'($urandom_range(0, level - 1));
            r = $urandom_range(99);
            if (r < 8) val = '0;
            else if (r < 16) val = '1;
            else val = DATA_WIDTH'($urandom);
            send_request(cmd, pos, val);
        end
    endtask

    initial begin
        sb = new();
        i_rst_n         = 1'b0;
        req_if.valid    = 1'b0;
        req_if.cmd      = '0;
        req_if.position = '0;
        req_if.value    = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // no idling on either side
        run_directed();
        run_random(RANDOM_ITEMS / 4);
        // sender mostly idle
        send_idle_pct = 84;
        run_random(RANDOM_ITEMS / 4);
        // receiver mostly stalled
        send_idle_pct = 0;
        rcv_stall_pct = 84;
        run_random(RANDOM_ITEMS / 4);
        // light idling on both sides
        send_idle_pct = 14;
        rcv_stall_pct = 14;
        run_random(RANDOM_ITEMS - 3 * (RANDOM_ITEMS / 4));
        req_if.valid <= 1'b0;

        // drain outstanding responses, then settle
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("indexed_ordered_list_unit_tb passed");
        end else begin
            $display("indexed_ordered_list_unit_tb failed");
        end
        $finish;
    end
endmodule

@@ sim.f @@
hdl/iol_pkg.sv
hdl/iol_if.sv
hdl/iol_ctrl.sv
hdl/iol_cell.sv
hdl/indexed_ordered_list_unit.sv
tb/sv/indexed_ordered_list_unit_tb.sv
